@@ rtl/tcsw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console scroll writer package
// Geometry, command codes and item types shared by the console files.
// ----------------------------------------------------------------------------
package tcsw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = 11;
	localparam int RAM_AW = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int CELL_W = 16;

	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] CELL_COUNT = ADDR_W'(CELLS);
	localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0700;

	typedef struct packed {
		logic [1:0]        command;
		logic [7:0]        char_code;
		logic [ADDR_W-1:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cursor_pos;
		logic              scrolled;
		logic [CELL_W-1:0] cell_data;
	} res_t;

endpackage

@@ rtl/text_console_scroll_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console scroll writer
// 80x25 text screen of 16-bit cells with cursor, newline, scroll, clear and read.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and done is high for a
// single cycle when its result is on result; the receiver cannot stall it. The
// screen lives in one RAM with registered read data, so a NUL, a plain newline,
// an out-of-range read or an unused command answers in the cycle after the item
// is taken, and a put character or a read answers from the state that follows
// (ST_PUT_WR or ST_READ: read, then write back for a put). A scroll copies 1920
// cells and fills 80 more through the same RAM port, one cell per cycle, and a
// scrolling newline answers as the last fill cell is written; a put character
// that scrolls first then reads and writes its cell before it answers. A clear
// writes all 2000 cells and answers as the last one is written. busy stays
// high for the whole sequence. blank_cell may be written through cfg at any
// time that no item is in progress; cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_console_scroll_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  tcsw_pkg::cmd_t                 cmd,
	output logic                           done,
	output tcsw_pkg::res_t                 result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcsw_pkg::CELL_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PUT_RD = 3'd1;
	localparam logic [2:0] ST_PUT_WR = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_COPY   = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_CLEAR  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [tcsw_pkg::ADDR_W-1:0] cnt_q, cnt_d;
	logic [tcsw_pkg::ADDR_W-1:0] cursor_q, cursor_d;
	logic [tcsw_pkg::ADDR_W-1:0] row_q, row_d;
	logic [tcsw_pkg::COL_W-1:0]  col_q, col_d;
	logic [7:0] char_q, char_d;
	logic scr_q, scr_d;
	logic pend_q, pend_d;
	logic [tcsw_pkg::CELL_W-1:0] blank_q;
	logic done_q, done_d;
	tcsw_pkg::res_t result_q, result_d;
	logic [tcsw_pkg::CELL_W-1:0] data_d;

	logic wr_v_s1, wr_v_d;
	logic wr_blank_s1, wr_blank_d;
	logic [tcsw_pkg::RAM_AW-1:0] wr_addr_s1, wr_addr_d;

	logic put_wr;
	logic [tcsw_pkg::RAM_AW-1:0] rd_addr;
	logic [tcsw_pkg::RAM_AW-1:0] ram_waddr;
	logic [tcsw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
	logic ram_we;

	assign busy      = (state_q != ST_IDLE) | wr_v_s1;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cursor_d   = cursor_q;
		row_d      = row_q;
		col_d      = col_q;
		char_d     = char_q;
		scr_d      = scr_q;
		pend_d     = pend_q;
		done_d     = 1'b0;
		data_d     = '0;
		put_wr     = 1'b0;
		rd_addr    = cursor_q[tcsw_pkg::RAM_AW-1:0];
		wr_v_d     = 1'b0;
		wr_blank_d = 1'b0;
		wr_addr_d  = cnt_q[tcsw_pkg::RAM_AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					char_d = cmd.char_code;
					scr_d  = 1'b0;
					pend_d = 1'b0;
					case (cmd.command)
						tcsw_pkg::CMD_PUT: begin
							if (cmd.char_code == tcsw_pkg::CH_NUL) begin
								done_d = 1'b1;
							end else if (cmd.char_code == tcsw_pkg::CH_NEWLINE) begin
								if (cursor_q >= tcsw_pkg::LAST_ROW) begin
									state_d = ST_COPY;
									cnt_d   = '0;
									scr_d   = 1'b1;
								end else begin
									cursor_d = row_q + tcsw_pkg::ROW_STEP;
									row_d    = row_q + tcsw_pkg::ROW_STEP;
									col_d    = '0;
									done_d   = 1'b1;
								end
							end else if (cursor_q >= tcsw_pkg::CELL_COUNT) begin
								state_d = ST_COPY;
								cnt_d   = '0;
								scr_d   = 1'b1;
								pend_d  = 1'b1;
							end else begin
								state_d = ST_PUT_WR;
							end
						end
						tcsw_pkg::CMD_CLEAR: begin
							state_d = ST_CLEAR;
							cnt_d   = '0;
						end
						tcsw_pkg::CMD_READ: begin
							if (cmd.cell_index < tcsw_pkg::CELL_COUNT) begin
								rd_addr = cmd.cell_index[tcsw_pkg::RAM_AW-1:0];
								state_d = ST_READ;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_PUT_RD: begin
				state_d = ST_PUT_WR;
			end
			ST_PUT_WR: begin
				put_wr   = 1'b1;
				cursor_d = cursor_q + 1'b1;
				if (col_q == tcsw_pkg::COL_LAST) begin
					col_d = '0;
					row_d = row_q + tcsw_pkg::ROW_STEP;
				end else begin
					col_d = col_q + 1'b1;
				end
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ: begin
				data_d  = ram_rdata;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				rd_addr = tcsw_pkg::RAM_AW'(cnt_q + tcsw_pkg::ROW_STEP);
				wr_v_d  = 1'b1;
				if (cnt_q == tcsw_pkg::LAST_COPY) begin
					state_d = ST_FILL;
					cnt_d   = tcsw_pkg::LAST_ROW;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FILL: begin
				wr_v_d     = 1'b1;
				wr_blank_d = 1'b1;
				if (cnt_q == tcsw_pkg::LAST_CELL) begin
					cursor_d = tcsw_pkg::LAST_ROW;
					row_d    = tcsw_pkg::LAST_ROW;
					col_d    = '0;
					if (pend_q) begin
						state_d = ST_PUT_RD;
					end else begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				wr_v_d     = 1'b1;
				wr_blank_d = 1'b1;
				if (cnt_q == tcsw_pkg::LAST_CELL) begin
					cursor_d = '0;
					row_d    = '0;
					col_d    = '0;
					done_d   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		result_d.cursor_pos = cursor_d;
		result_d.scrolled   = scr_d;
		result_d.cell_data  = data_d;
	end

	assign ram_we    = wr_v_s1 | put_wr;
	assign ram_waddr = wr_v_s1 ? wr_addr_s1 : cursor_q[tcsw_pkg::RAM_AW-1:0];
	assign ram_wdata = wr_v_s1 ? (wr_blank_s1 ? blank_q : ram_rdata)
	                           : {ram_rdata[15:8], char_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			cursor_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			scr_q    <= 1'b0;
			pend_q   <= 1'b0;
			blank_q  <= tcsw_pkg::BLANK_RESET;
			done_q   <= 1'b0;
			wr_v_s1  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			cursor_q <= cursor_d;
			row_q    <= row_d;
			col_q    <= col_d;
			scr_q    <= scr_d;
			pend_q   <= pend_d;
			done_q   <= done_d;
			wr_v_s1  <= wr_v_d;
			if (cfg_valid && cfg_ready) begin
				blank_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q      <= char_d;
		wr_blank_s1 <= wr_blank_d;
		wr_addr_s1  <= wr_addr_d;
		if (done_d) begin
			result_q <= result_d;
		end
	end

	tcsw_ram #(
		.WIDTH(tcsw_pkg::CELL_W),
		.DEPTH(tcsw_pkg::CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

endmodule

@@ rtl/tcsw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tcsw_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console scroll writer checker
// Port-level properties of the console, bound to the top level.
// ----------------------------------------------------------------------------
module tcsw_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input tcsw_pkg::res_t              result
);

	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("Accepted item neither answered nor held busy.");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) && !busy |=> !done)
		else $error("Result strobe without an item in progress.");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.cursor_pos <= tcsw_pkg::CELL_COUNT)
		else $error("Cursor beyond the end of the screen.");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.scrolled |-> result.cursor_pos == tcsw_pkg::LAST_ROW ||
			result.cursor_pos == tcsw_pkg::LAST_ROW + 1'b1)
		else $error("Scroll left the cursor off the last row start.");

endmodule

bind text_console_scroll_writer tcsw_chk u_tcsw_chk (.*);
